### src/chwc_pkg.sv
// ----------------------------------------------------------------------------
// chwc_pkg
// Shared types and codes for the chained hash word counter.
// ----------------------------------------------------------------------------
`default_nettype none

package chwc_pkg;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned CFG_W    = 13;
    localparam logic [31:0] HASH_MULT = 32'd239;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ERASE = 2'd1,
        OP_COUNT = 2'd2,
        OP_SPARE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_INCREMENT = 3'd1,
        ST_ABSENT    = 3'd2,
        ST_ZERO      = 3'd3,
        ST_COUNTED   = 3'd4,
        ST_POOL_FULL = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic       last_char;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   occurrences;
    } out_word_t;

endpackage

`default_nettype wire

### src/chained_hash_word_counter_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_word_counter_unit
// Word counter: hashes bytes, walks a bucket chain, adds/erases/counts words.
// ----------------------------------------------------------------------------
// Flow: a byte that is not last is folded into the running hash. A last byte
//   passes the remainder unit (32 steps and a handoff), a head lookup, a
//   compare per chain entry passed over, then an update and post of the word
//   (an insert also links the entry in), plus any wait for the output slot.
// One word is handled at a time; the divider and the chain walk set the pace.
// Reset: async, active low. After reset the bucket head table is swept to
//   empty entry by entry; no input word is taken during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_word_counter_unit #(
    parameter int unsigned MAX_BUCKETS  = 4096,
    parameter int unsigned POOL_ENTRIES = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire chwc_pkg::in_word_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output chwc_pkg::out_word_t                    out_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [chwc_pkg::CFG_W-1:0]        cfg_wr_data
);

    // widths: divisor holds MAX_BUCKETS itself, pointers hold index plus one
    localparam int unsigned DW = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int unsigned PW = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int unsigned CW = chwc_pkg::COUNT_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_HEAD  = 9'b000001000,
        S_LOAD  = 9'b000010000,
        S_CHECK = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_ACT   = 9'b010000000,
        S_LINK  = 9'b100000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [chwc_pkg::CFG_W-1:0]     bcount_reg;
    logic [chwc_pkg::HASH_W-1:0]    hash_reg, hash_next;
    logic [chwc_pkg::HASH_W-1:0]    key_reg, key_next;
    logic [1:0]                     op_reg, op_next;
    logic [BW-1:0]                  bucket_reg, bucket_next;
    logic [BW-1:0]                  clr_reg, clr_next;
    logic [PW-1:0]                  ptr_reg, ptr_next;
    logic [PW-1:0]                  tail_reg, tail_next;
    logic                           hit_reg, hit_next;
    logic [CW-1:0]                  total_reg, total_next;
    logic [PW-1:0]                  pool_reg, pool_next;
    logic                           out_valid_reg, out_valid_next;
    chwc_pkg::out_word_t            out_reg, out_next;

    // bucket head table and entry pool
    logic [PW-1:0]                  head_mem [MAX_BUCKETS];
    logic [chwc_pkg::HASH_W-1:0]    key_mem  [POOL_ENTRIES];
    logic [CW-1:0]                  total_mem[POOL_ENTRIES];
    logic [PW-1:0]                  link_mem [POOL_ENTRIES];
    logic [PW-1:0]                  head_rd;
    logic [chwc_pkg::HASH_W-1:0]    key_rd;
    logic [CW-1:0]                  total_rd;
    logic [PW-1:0]                  link_rd;

    logic                           head_we;
    logic [BW-1:0]                  head_wa;
    logic [PW-1:0]                  head_wd;
    logic                           entry_we;
    logic                           total_we;
    logic [IW-1:0]                  total_wa;
    logic [CW-1:0]                  total_wd;
    logic                           link_we;
    logic [IW-1:0]                  link_wa;
    logic [PW-1:0]                  link_wd;
    logic [IW-1:0]                  ent_ra;
    logic [IW-1:0]                  new_idx;
    logic [PW-1:0]                  new_ptr;

    logic                           div_start;
    logic                           div_done;
    logic [DW-1:0]                  div_rem;
    logic [DW-1:0]                  divisor;
    logic [chwc_pkg::HASH_W-1:0]    dividend;
    logic [chwc_pkg::HASH_W-1:0]    hash_step;
    logic                           in_fire;
    logic                           out_free;
    logic                           pool_full;

    // bucket count: zero acts as one, large values clamp to the table size
    always_comb
    begin
        if (bcount_reg == '0)
        begin
            divisor = DW'(1);
        end
        else if (32'(bcount_reg) > 32'(MAX_BUCKETS))
        begin
            divisor = DW'(MAX_BUCKETS);
        end
        else
        begin
            divisor = DW'(bcount_reg);
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign pool_full = (pool_reg == PW'(POOL_ENTRIES));
    assign new_idx   = IW'(pool_reg);
    assign new_ptr   = pool_reg + PW'(1);
    assign ent_ra    = IW'(ptr_reg - PW'(1));

    // hash * 239 plus the sign-extended byte, wrapping
    assign hash_step = 32'(hash_reg * chwc_pkg::HASH_MULT)
                     + {{24{in_data.char_code[7]}}, in_data.char_code};

    // floored modulo: negative keys divide the one's complement
    assign dividend  = hash_step[31] ? ~hash_step : hash_step;
    assign div_start = in_fire && in_data.last_char;

    chwc_divider #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        key_next       = key_reg;
        op_next        = op_reg;
        bucket_next    = bucket_reg;
        clr_next       = clr_reg;
        ptr_next       = ptr_reg;
        tail_next      = tail_reg;
        hit_next       = hit_reg;
        total_next     = total_reg;
        pool_next      = pool_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        head_we        = 1'b0;
        head_wa        = bucket_reg;
        head_wd        = new_ptr;
        entry_we       = 1'b0;
        total_we       = 1'b0;
        total_wa       = ent_ra;
        total_wd       = total_reg;
        link_we        = 1'b0;
        link_wa        = new_idx;
        link_wd        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we  = 1'b1;
                head_wa  = clr_reg;
                head_wd  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BW'(MAX_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.last_char)
                    begin
                        hash_next  = '0;
                        key_next   = hash_step;
                        op_next    = in_data.opcode;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        hash_next = hash_step;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (key_reg[31])
                    begin
                        bucket_next = BW'(divisor - DW'(1) - div_rem);
                    end
                    else
                    begin
                        bucket_next = BW'(div_rem);
                    end
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ptr_next   = head_rd;
                tail_next  = '0;
                hit_next   = 1'b0;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (ptr_reg == '0) ? S_ACT : S_CMP;
            end
            S_CMP:
            begin
                if (key_rd == key_reg)
                begin
                    hit_next   = 1'b1;
                    total_next = total_rd;
                    state_next = S_ACT;
                end
                else
                begin
                    tail_next  = ptr_reg;
                    ptr_next   = link_rd;
                    state_next = S_CHECK;
                end
            end
            S_ACT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    priority if (op_reg == chwc_pkg::OP_ADD)
                    begin
                        if (hit_reg)
                        begin
                            total_we = 1'b1;
                            total_wd = (total_reg == '1) ? total_reg : total_reg + 1'b1;
                            out_next = '{chwc_pkg::ST_INCREMENT, total_wd};
                        end
                        else if (pool_full)
                        begin
                            out_next = '{chwc_pkg::ST_POOL_FULL, '0};
                        end
                        else
                        begin
                            // fresh entry; chain hookup follows next cycle
                            entry_we       = 1'b1;
                            total_we       = 1'b1;
                            total_wa       = new_idx;
                            total_wd       = CW'(1);
                            link_we        = 1'b1;
                            out_valid_next = 1'b0;
                            state_next     = S_LINK;
                        end
                    end
                    else if (op_reg == chwc_pkg::OP_ERASE)
                    begin
                        if (!hit_reg)
                        begin
                            out_next = '{chwc_pkg::ST_ABSENT, '0};
                        end
                        else if (total_reg == '0)
                        begin
                            out_next = '{chwc_pkg::ST_ZERO, '0};
                        end
                        else
                        begin
                            total_we = 1'b1;
                            total_wd = total_reg - 1'b1;
                            out_next = '{chwc_pkg::ST_COUNTED, total_wd};
                        end
                    end
                    else
                    begin
                        out_next = '{chwc_pkg::ST_COUNTED, hit_reg ? total_reg : '0};
                    end
                end
            end
            S_LINK:
            begin
                if (tail_reg == '0)
                begin
                    head_we = 1'b1;
                end
                else
                begin
                    link_we = 1'b1;
                    link_wa = IW'(tail_reg - PW'(1));
                    link_wd = new_ptr;
                end
                pool_next      = new_ptr;
                out_valid_next = 1'b1;
                out_next       = '{chwc_pkg::ST_INSERTED, CW'(1)};
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            bcount_reg    <= chwc_pkg::CFG_W'(4096);
            hash_reg      <= '0;
            clr_reg       <= '0;
            pool_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            clr_reg       <= clr_next;
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bcount_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        op_reg     <= op_next;
        bucket_reg <= bucket_next;
        ptr_reg    <= ptr_next;
        tail_reg   <= tail_next;
        hit_reg    <= hit_next;
        total_reg  <= total_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd <= head_mem[bucket_reg];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            key_mem[new_idx] <= key_reg;
        end
        key_rd <= key_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (total_we)
        begin
            total_mem[total_wa] <= total_wd;
        end
        total_rd <= total_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd <= link_mem[ent_ra];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // pool never runs past its size
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pool_reg <= PW'(POOL_ENTRIES))
        else $error("pool index past end");

    // pool grows by one, and only on a chain hookup
    a_pool_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pool_reg != $past(pool_reg)) |-> ($past(state_reg) == S_LINK
            && pool_reg == $past(pool_reg) + PW'(1)))
        else $error("pool index moved unexpectedly");

    // head sweep happens only right after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clear sweep re-entered");

    // a result is posted only when the output slot was free
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && (state_reg == S_ACT || state_reg == S_LINK))
            |=> $stable(out_reg))
        else $error("output overwritten while held");

endmodule

`default_nettype wire

### src/chwc_divider.sv
// ----------------------------------------------------------------------------
// chwc_divider
// Restoring divider, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
`default_nettype none

module chwc_divider #(
    parameter int unsigned DW = 13
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [chwc_pkg::HASH_W-1:0]     dividend,
    input  wire logic [DW-1:0]                   divisor,
    output logic                                 done,
    output logic [DW-1:0]                        remainder
);

    logic [chwc_pkg::HASH_W-1:0]  quo_reg;
    logic [DW-1:0]                rem_reg;
    logic [chwc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [DW:0]                  trial;
    logic [DW-1:0]                rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[chwc_pkg::HASH_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = DW'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == chwc_pkg::DIV_CNT_W'(chwc_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[chwc_pkg::HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
